// ----- rtl/fusd_pkg.sv -----
// Shared types, character constants and helper functions for the
// form-urlencoded stream decoder. No dependencies.
`timescale 1ns / 1ps

package fusd_pkg;

  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharPct   = 8'h25;
  localparam logic [7:0] CharEq    = 8'h3D;
  localparam logic [7:0] CharAmp   = 8'h26;
  localparam logic [7:0] CharSpace = 8'h20;

  localparam logic [1:0] HeldNone  = 2'd0;
  localparam logic [1:0] HeldPct   = 2'd1;
  localparam logic [1:0] HeldDigit = 2'd2;

  localparam int unsigned MaxResults = 4;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       segment_end;
    logic       segment_kind;
  } result_t;

  // All results caused by one input byte; cnt is 0..4
  typedef struct packed {
    result_t [MaxResults-1:0] res;
    logic [2:0]               cnt;
  } run_t;

  function automatic hex_t hex_value(logic [7:0] c);
    hex_t       h;
    logic [7:0] d;
    h = '0;
    d = 8'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30;
      h.ok = 1'b1;
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d = c - 8'd55;  // c - 'A' + 10
      h.ok = 1'b1;
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d = c - 8'd87;  // c - 'a' + 10
      h.ok = 1'b1;
    end
    h.val = d[3:0];
    return h;
  endfunction

  function automatic run_t push(run_t r, logic [7:0] b, logic bv, logic e, logic k);
    run_t o;
    o = r;
    if (o.cnt < 3'(MaxResults)) begin
      o.res[o.cnt[1:0]].out_byte     = bv ? b : 8'd0;
      o.res[o.cnt[1:0]].byte_valid   = bv;
      o.res[o.cnt[1:0]].segment_end  = e;
      o.res[o.cnt[1:0]].segment_kind = e ? k : 1'b0;
      o.cnt = o.cnt + 3'd1;
    end
    return o;
  endfunction

  // Emit a pending escape literally
  function automatic run_t flush(run_t r, logic [1:0] hc, logic [7:0] hh);
    run_t o;
    o = r;
    if (hc == HeldPct) begin
      o = push(o, CharPct, 1'b1, 1'b0, 1'b0);
    end else if (hc == HeldDigit) begin
      o = push(o, CharPct, 1'b1, 1'b0, 1'b0);
      o = push(o, hh, 1'b1, 1'b0, 1'b0);
    end
    return o;
  endfunction

  // Non-separator byte with no escape pending ('%' only sets the hold)
  function automatic run_t plain(run_t r, logic [7:0] c);
    run_t o;
    o = r;
    if (c == CharPlus) begin
      o = push(o, CharSpace, 1'b1, 1'b0, 1'b0);
    end else if (c != CharPct) begin
      o = push(o, c, 1'b1, 1'b0, 1'b0);
    end
    return o;
  endfunction

endpackage

// ----- rtl/fusd_decode.sv -----
// Escape/segment state and the single-pass decode of one byte into a run
// of up to four results. Depends on fusd_pkg.
`timescale 1ns / 1ps

module fusd_decode (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [7:0]      byte_i,
  input  logic            final_i,
  input  logic            step_i,
  output fusd_pkg::run_t  run_o
);

  logic [1:0] held_q, held_d;
  logic [7:0] hex_q, hex_d;
  logic       nonempty_q, nonempty_d;

  fusd_pkg::hex_t hv, hi;
  fusd_pkg::run_t run;

  assign hv = fusd_pkg::hex_value(byte_i);
  assign hi = fusd_pkg::hex_value(hex_q);

  always_comb begin
    run        = '0;
    held_d     = held_q;
    hex_d      = hex_q;
    nonempty_d = nonempty_q;
    if (byte_i == fusd_pkg::CharEq || byte_i == fusd_pkg::CharAmp) begin
      run    = fusd_pkg::flush(run, held_d, hex_d);
      held_d = fusd_pkg::HeldNone;
      hex_d  = 8'd0;
      run    = fusd_pkg::push(run, 8'd0, 1'b0, 1'b1, byte_i == fusd_pkg::CharAmp);
      nonempty_d = 1'b0;
    end else begin
      nonempty_d = 1'b1;
      if (held_q == fusd_pkg::HeldPct) begin
        if (hv.ok) begin
          held_d = fusd_pkg::HeldDigit;
          hex_d  = byte_i;
        end else begin
          run    = fusd_pkg::push(run, fusd_pkg::CharPct, 1'b1, 1'b0, 1'b0);
          run    = fusd_pkg::plain(run, byte_i);
          held_d = (byte_i == fusd_pkg::CharPct) ? fusd_pkg::HeldPct : fusd_pkg::HeldNone;
        end
      end else if (held_q == fusd_pkg::HeldDigit) begin
        if (hv.ok) begin
          run    = fusd_pkg::push(run, {(hi.ok ? hi.val : 4'd0), hv.val},
                                  1'b1, 1'b0, 1'b0);
          held_d = fusd_pkg::HeldNone;
          hex_d  = 8'd0;
        end else begin
          run    = fusd_pkg::flush(run, held_q, hex_q);
          hex_d  = 8'd0;
          run    = fusd_pkg::plain(run, byte_i);
          held_d = (byte_i == fusd_pkg::CharPct) ? fusd_pkg::HeldPct : fusd_pkg::HeldNone;
        end
      end else begin
        // held state three is treated as nothing pending
        run    = fusd_pkg::plain(run, byte_i);
        held_d = (byte_i == fusd_pkg::CharPct) ? fusd_pkg::HeldPct : fusd_pkg::HeldNone;
      end
    end
    if (final_i) begin
      run = fusd_pkg::flush(run, held_d, hex_d);
      if (nonempty_d) begin
        run = fusd_pkg::push(run, 8'd0, 1'b0, 1'b1, 1'b1);
      end
      held_d     = fusd_pkg::HeldNone;
      hex_d      = 8'd0;
      nonempty_d = 1'b0;
    end
  end

  assign run_o = run;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q     <= fusd_pkg::HeldNone;
      hex_q      <= 8'd0;
      nonempty_q <= 1'b0;
    end else if (step_i) begin
      held_q     <= held_d;
      hex_q      <= hex_d;
      nonempty_q <= nonempty_d;
    end
  end

endmodule

// ----- rtl/fusd_run_buf.sv -----
// Result register: holds one run of results and hands them out one
// transfer at a time, flagging the last of the run. Depends on fusd_pkg.
`timescale 1ns / 1ps

module fusd_run_buf (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  fusd_pkg::run_t  run_i,
  output logic            free_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [7:0]      out_byte_o,
  output logic            byte_valid_o,
  output logic            segment_end_o,
  output logic            segment_kind_o,
  output logic            run_last_o
);

  fusd_pkg::result_t [fusd_pkg::MaxResults-1:0] res_q;
  logic [1:0] last_q, idx_q;
  logic       busy_q;
  logic       take, at_last;
  logic [2:0] last_full;

  assign take    = busy_q && !out_stall_i;
  assign at_last = idx_q == last_q;
  assign free_o  = !busy_q || (take && at_last);
  assign last_full = run_i.cnt - 3'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= 2'd0;
      last_q <= 2'd0;
    end else if (load_i && free_o) begin
      busy_q <= 1'b1;
      idx_q  <= 2'd0;
      last_q <= last_full[1:0];
    end else if (take) begin
      if (at_last) begin
        busy_q <= 1'b0;
      end else begin
        idx_q <= idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && free_o) begin
      res_q <= run_i.res;
    end
  end

  assign out_valid_o    = busy_q;
  assign out_byte_o     = res_q[idx_q].out_byte;
  assign byte_valid_o   = res_q[idx_q].byte_valid;
  assign segment_end_o  = res_q[idx_q].segment_end;
  assign segment_kind_o = res_q[idx_q].segment_kind;
  assign run_last_o     = at_last;

endmodule

// ----- rtl/form_urlencoded_stream_decoder_core.sv -----
// Form-urlencoded stream decoder, top level. Depends on fusd_pkg,
// fusd_decode and fusd_run_buf.
// A byte is held in the input register, its results in the result register.
// Throughput: 1 byte per cycle with an unstalled output while each byte
// yields at most one result; n results take n output transfers (n <= 4).
// Reset (async, active low) empties both registers and clears escape state.
`timescale 1ns / 1ps

module form_urlencoded_stream_decoder_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       is_final_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       byte_valid_o,
  output logic       segment_end_o,
  output logic       segment_kind_o,
  output logic       run_last_o
);

  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       in_fin_q;
  logic       advance, free, accept;
  fusd_pkg::run_t run;

  // a byte with no results may step past a busy result register
  assign advance    = in_vld_q && (run.cnt == 3'd0 || free);
  assign in_stall_o = in_vld_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (accept) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_byte_q <= in_byte_i;
      in_fin_q  <= is_final_i;
    end
  end

  fusd_decode u_decode (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .byte_i  (in_byte_q),
    .final_i (in_fin_q),
    .step_i  (advance),
    .run_o   (run)
  );

  fusd_run_buf u_run_buf (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .load_i         (advance && run.cnt != 3'd0),
    .run_i          (run),
    .free_o         (free),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_byte_o     (out_byte_o),
    .byte_valid_o   (byte_valid_o),
    .segment_end_o  (segment_end_o),
    .segment_kind_o (segment_kind_o),
    .run_last_o     (run_last_o)
  );

endmodule
